### sv/tfn_pkg.sv
// ----------------------------------------------------------------------------
// tfn_pkg
// Shared types and widths for the triangle face normal pipeline.
// ----------------------------------------------------------------------------
`default_nettype none
package tfn_pkg;

    localparam int COORD_BITS       = 16;
    localparam int NORMAL_FRAC_BITS = 14;

    localparam int FIELD_W   = 16;
    localparam int OUT_W     = 16;
    localparam int EDGE_W    = COORD_BITS + 1;
    localparam int PROD_W    = 2 * EDGE_W;
    localparam int CROSS_W   = PROD_W + 1;
    localparam int MAG_W     = 31;
    localparam int BLEN_W    = $clog2(CROSS_W + 1);
    localparam int SQ_W      = 2 * MAG_W;
    localparam int SUM_W     = 64;
    localparam int SQRT_STG  = SUM_W / 2;
    localparam int LEN_W     = SUM_W / 2;
    localparam int Q_W       = NORMAL_FRAC_BITS + 1;
    localparam int NUM_W     = MAG_W + NORMAL_FRAC_BITS + 1;
    localparam int FRONT_STG = 8;
    localparam int LATENCY   = FRONT_STG + SQRT_STG + Q_W + 1;

    localparam logic [Q_W-1:0] ONE_Q = Q_W'(1) << NORMAL_FRAC_BITS;

    typedef struct packed {
        logic signed [FIELD_W-1:0] p1_x;
        logic signed [FIELD_W-1:0] p1_y;
        logic signed [FIELD_W-1:0] p1_z;
        logic signed [FIELD_W-1:0] p2_x;
        logic signed [FIELD_W-1:0] p2_y;
        logic signed [FIELD_W-1:0] p2_z;
        logic signed [FIELD_W-1:0] p3_x;
        logic signed [FIELD_W-1:0] p3_y;
        logic signed [FIELD_W-1:0] p3_z;
    } t_tri;

    typedef struct packed {
        logic signed [OUT_W-1:0] normal_x;
        logic signed [OUT_W-1:0] normal_y;
        logic signed [OUT_W-1:0] normal_z;
        logic                    degenerate;
    } t_result;

    typedef struct packed {
        logic [2:0][MAG_W-1:0] m;
        logic [2:0]            neg;
        logic                  degen;
    } t_side;

endpackage
`default_nettype wire

### sv/triangle_face_normal_unit.sv
// ----------------------------------------------------------------------------
// triangle_face_normal_unit
// Unit face normal (signed Q1.14) of one triangle given in signed Q8.8.
// ----------------------------------------------------------------------------
// A triangle is taken on every cycle that start is high; busy is always low.
// The result appears on o_result with o_strobe high for one cycle, after
// 8 front stages (edges, cross product, normalization, sum of squares),
// 32 square-root stages, 15 divider stages and one output register.
// Zero-area triangles flag degenerate, normal 0.
`default_nettype none
module triangle_face_normal_unit (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             start,
    output logic                  busy,
    input  wire tfn_pkg::t_tri    i_tri,
    output logic                  o_strobe,
    output tfn_pkg::t_result      o_result
);

    logic                        w_f_v, w_s_v;
    logic [tfn_pkg::SUM_W-1:0]   w_sum;
    logic [tfn_pkg::LEN_W-1:0]   w_len;
    tfn_pkg::t_side              w_f_side, w_s_side;

    assign busy = 1'b0;

    tfn_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (start),
        .i_tri   (i_tri),
        .o_valid (w_f_v),
        .o_sum   (w_sum),
        .o_side  (w_f_side)
    );

    tfn_sqrt u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_f_v),
        .i_sum   (w_sum),
        .i_side  (w_f_side),
        .o_valid (w_s_v),
        .o_len   (w_len),
        .o_side  (w_s_side)
    );

    tfn_div u_div (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (w_s_v),
        .i_len    (w_len),
        .i_side   (w_s_side),
        .o_strobe (o_strobe),
        .o_result (o_result)
    );

endmodule
`default_nettype wire

### sv/tfn_front.sv
// ----------------------------------------------------------------------------
// tfn_front
// Edges, exact cross product, magnitudes, normalization and sum of squares.
// ----------------------------------------------------------------------------
`default_nettype none
module tfn_front (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_valid,
    input  wire tfn_pkg::t_tri  i_tri,
    output logic                o_valid,
    output logic [tfn_pkg::SUM_W-1:0] o_sum,
    output tfn_pkg::t_side      o_side
);

    logic [tfn_pkg::FRONT_STG-1:0] r_vld;

    logic signed [tfn_pkg::EDGE_W-1:0]  w_p [9];
    logic signed [tfn_pkg::EDGE_W-1:0]  r_a [3];
    logic signed [tfn_pkg::EDGE_W-1:0]  r_b [3];
    logic signed [tfn_pkg::PROD_W-1:0]  r_pr [6];
    logic signed [tfn_pkg::CROSS_W-1:0] w_c [3];
    logic [tfn_pkg::CROSS_W-1:0]        r_mag3 [3];
    logic [tfn_pkg::CROSS_W-1:0]        r_mag4 [3];
    logic [tfn_pkg::CROSS_W-1:0]        r_mag5 [3];
    logic [2:0]                         r_neg3, r_neg4, r_neg5, r_neg6, r_neg7, r_neg8;
    logic [tfn_pkg::CROSS_W-1:0]        w_mx, r_mx;
    logic [tfn_pkg::BLEN_W-1:0]         w_blen, r_blen;
    logic                               r_zero5, r_zero6, r_zero7, r_zero8;
    logic [tfn_pkg::MAG_W-1:0]          w_m [3];
    logic [tfn_pkg::MAG_W-1:0]          r_m6 [3];
    logic [tfn_pkg::MAG_W-1:0]          r_m7 [3];
    logic [tfn_pkg::MAG_W-1:0]          r_m8 [3];
    logic [tfn_pkg::SQ_W-1:0]           r_sq [3];
    logic [tfn_pkg::SUM_W-1:0]          r_sum;

    always_comb begin
        w_p[0] = tfn_pkg::EDGE_W'(signed'(i_tri.p1_x[tfn_pkg::COORD_BITS-1:0]));
        w_p[1] = tfn_pkg::EDGE_W'(signed'(i_tri.p1_y[tfn_pkg::COORD_BITS-1:0]));
        w_p[2] = tfn_pkg::EDGE_W'(signed'(i_tri.p1_z[tfn_pkg::COORD_BITS-1:0]));
        w_p[3] = tfn_pkg::EDGE_W'(signed'(i_tri.p2_x[tfn_pkg::COORD_BITS-1:0]));
        w_p[4] = tfn_pkg::EDGE_W'(signed'(i_tri.p2_y[tfn_pkg::COORD_BITS-1:0]));
        w_p[5] = tfn_pkg::EDGE_W'(signed'(i_tri.p2_z[tfn_pkg::COORD_BITS-1:0]));
        w_p[6] = tfn_pkg::EDGE_W'(signed'(i_tri.p3_x[tfn_pkg::COORD_BITS-1:0]));
        w_p[7] = tfn_pkg::EDGE_W'(signed'(i_tri.p3_y[tfn_pkg::COORD_BITS-1:0]));
        w_p[8] = tfn_pkg::EDGE_W'(signed'(i_tri.p3_z[tfn_pkg::COORD_BITS-1:0]));
    end

    always_comb begin
        w_c[0] = tfn_pkg::CROSS_W'(r_pr[0]) - tfn_pkg::CROSS_W'(r_pr[1]);
        w_c[1] = tfn_pkg::CROSS_W'(r_pr[2]) - tfn_pkg::CROSS_W'(r_pr[3]);
        w_c[2] = tfn_pkg::CROSS_W'(r_pr[4]) - tfn_pkg::CROSS_W'(r_pr[5]);
    end

    always_comb begin
        w_mx = (r_mag3[0] > r_mag3[1]) ? r_mag3[0] : r_mag3[1];
        if (r_mag3[2] > w_mx) begin
            w_mx = r_mag3[2];
        end
    end

    always_comb begin
        w_blen = '0;
        for (int i = 0; i < tfn_pkg::CROSS_W; i++) begin
            if (r_mx[i]) begin
                w_blen = tfn_pkg::BLEN_W'(i + 1);
            end
        end
    end

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            if (r_blen > tfn_pkg::BLEN_W'(tfn_pkg::MAG_W)) begin
                w_m[k] = tfn_pkg::MAG_W'(r_mag5[k] >> (r_blen - tfn_pkg::BLEN_W'(tfn_pkg::MAG_W)));
            end else begin
                w_m[k] = tfn_pkg::MAG_W'(r_mag5[k] << (tfn_pkg::BLEN_W'(tfn_pkg::MAG_W) - r_blen));
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= {r_vld[tfn_pkg::FRONT_STG-2:0], i_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        for (int k = 0; k < 3; k++) begin
            r_a[k]    <= w_p[k] - w_p[3 + k];
            r_b[k]    <= w_p[k] - w_p[6 + k];
            r_neg3[k] <= w_c[k][tfn_pkg::CROSS_W-1];
            r_mag3[k] <= w_c[k][tfn_pkg::CROSS_W-1] ? unsigned'(-w_c[k]) : unsigned'(w_c[k]);
            r_mag4[k] <= r_mag3[k];
            r_mag5[k] <= r_mag4[k];
            r_m6[k]   <= w_m[k];
            r_m7[k]   <= r_m6[k];
            r_m8[k]   <= r_m7[k];
            r_sq[k]   <= tfn_pkg::SQ_W'(r_m6[k]) * tfn_pkg::SQ_W'(r_m6[k]);
        end
        r_pr[0] <= tfn_pkg::PROD_W'(r_a[1]) * tfn_pkg::PROD_W'(r_b[2]);
        r_pr[1] <= tfn_pkg::PROD_W'(r_b[1]) * tfn_pkg::PROD_W'(r_a[2]);
        r_pr[2] <= tfn_pkg::PROD_W'(r_b[0]) * tfn_pkg::PROD_W'(r_a[2]);
        r_pr[3] <= tfn_pkg::PROD_W'(r_a[0]) * tfn_pkg::PROD_W'(r_b[2]);
        r_pr[4] <= tfn_pkg::PROD_W'(r_a[0]) * tfn_pkg::PROD_W'(r_b[1]);
        r_pr[5] <= tfn_pkg::PROD_W'(r_b[0]) * tfn_pkg::PROD_W'(r_a[1]);
        r_neg4  <= r_neg3;
        r_neg5  <= r_neg4;
        r_neg6  <= r_neg5;
        r_neg7  <= r_neg6;
        r_neg8  <= r_neg7;
        r_mx    <= w_mx;
        r_blen  <= w_blen;
        r_zero5 <= (r_mx == '0);
        r_zero6 <= r_zero5;
        r_zero7 <= r_zero6;
        r_zero8 <= r_zero7;
        r_sum   <= tfn_pkg::SUM_W'(r_sq[0]) + tfn_pkg::SUM_W'(r_sq[1])
                 + tfn_pkg::SUM_W'(r_sq[2]);
    end

    assign o_valid      = r_vld[tfn_pkg::FRONT_STG-1];
    assign o_sum        = r_sum;
    assign o_side.m[0]  = r_m8[0];
    assign o_side.m[1]  = r_m8[1];
    assign o_side.m[2]  = r_m8[2];
    assign o_side.neg   = r_neg8;
    assign o_side.degen = r_zero8;

endmodule
`default_nettype wire

### sv/tfn_sqrt.sv
// ----------------------------------------------------------------------------
// tfn_sqrt
// Pipelined integer square root, one result bit per stage.
// ----------------------------------------------------------------------------
`default_nettype none
module tfn_sqrt (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_valid,
    input  wire logic [tfn_pkg::SUM_W-1:0]   i_sum,
    input  wire tfn_pkg::t_side              i_side,
    output logic                             o_valid,
    output logic [tfn_pkg::LEN_W-1:0]        o_len,
    output tfn_pkg::t_side                   o_side
);

    logic [tfn_pkg::SUM_W-1:0] s_num  [tfn_pkg::SQRT_STG+1];
    logic [tfn_pkg::SUM_W-1:0] s_res  [tfn_pkg::SQRT_STG+1];
    tfn_pkg::t_side            s_side [tfn_pkg::SQRT_STG+1];
    logic                      s_v    [tfn_pkg::SQRT_STG+1];

    assign s_num[0]  = i_sum;
    assign s_res[0]  = '0;
    assign s_side[0] = i_side;
    assign s_v[0]    = i_valid;

    for (genvar g = 0; g < tfn_pkg::SQRT_STG; g++) begin : g_stage
        localparam logic [tfn_pkg::SUM_W-1:0] BIT =
            tfn_pkg::SUM_W'(1) << (tfn_pkg::SUM_W - 2 - 2 * g);
        logic [tfn_pkg::SUM_W-1:0] w_t, n_num, n_res;
        logic [tfn_pkg::SUM_W-1:0] r_num, r_res;
        tfn_pkg::t_side            r_side;
        logic                      r_v;

        always_comb begin
            w_t = s_res[g] + BIT;
            if (s_num[g] >= w_t) begin
                n_num = s_num[g] - w_t;
                n_res = (s_res[g] >> 1) + BIT;
            end else begin
                n_num = s_num[g];
                n_res = s_res[g] >> 1;
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v <= 1'b0;
            end else begin
                r_v <= s_v[g];
            end
        end

        always_ff @(posedge i_clk) begin
            r_num  <= n_num;
            r_res  <= n_res;
            r_side <= s_side[g];
        end

        assign s_num[g+1]  = r_num;
        assign s_res[g+1]  = r_res;
        assign s_side[g+1] = r_side;
        assign s_v[g+1]    = r_v;
    end

    assign o_valid = s_v[tfn_pkg::SQRT_STG];
    assign o_len   = s_res[tfn_pkg::SQRT_STG][tfn_pkg::LEN_W-1:0];
    assign o_side  = s_side[tfn_pkg::SQRT_STG];

endmodule
`default_nettype wire

### sv/tfn_div.sv
// ----------------------------------------------------------------------------
// tfn_div
// Three-lane pipelined restoring divider, sign and degenerate handling.
// ----------------------------------------------------------------------------
`default_nettype none
module tfn_div (
    input  wire logic                    i_clk,
    input  wire logic                    i_rst_n,
    input  wire logic                    i_valid,
    input  wire logic [tfn_pkg::LEN_W-1:0] i_len,
    input  wire tfn_pkg::t_side          i_side,
    output logic                         o_strobe,
    output tfn_pkg::t_result             o_result
);

    logic [tfn_pkg::NUM_W-1:0] s_rem  [tfn_pkg::Q_W+1][3];
    logic [tfn_pkg::Q_W-1:0]   s_q    [tfn_pkg::Q_W+1][3];
    logic [tfn_pkg::LEN_W-1:0] s_len  [tfn_pkg::Q_W+1];
    tfn_pkg::t_side            s_side [tfn_pkg::Q_W+1];
    logic                      s_v    [tfn_pkg::Q_W+1];

    logic [tfn_pkg::Q_W-1:0]   w_q [3];
    logic signed [tfn_pkg::OUT_W-1:0] w_n [3];
    tfn_pkg::t_result          r_result;
    logic                      r_strobe;

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            s_rem[0][k] = (tfn_pkg::NUM_W'(i_side.m[k]) << tfn_pkg::NORMAL_FRAC_BITS)
                        + tfn_pkg::NUM_W'(i_len >> 1);
            s_q[0][k]   = '0;
        end
    end
    assign s_len[0]  = i_len;
    assign s_side[0] = i_side;
    assign s_v[0]    = i_valid;

    for (genvar g = 0; g < tfn_pkg::Q_W; g++) begin : g_stage
        localparam int SH = tfn_pkg::Q_W - 1 - g;
        logic [tfn_pkg::NUM_W-1:0] w_d;
        logic [tfn_pkg::NUM_W-1:0] r_rem [3];
        logic [tfn_pkg::Q_W-1:0]   r_q   [3];
        logic [tfn_pkg::LEN_W-1:0] r_len;
        tfn_pkg::t_side            r_side;
        logic                      r_v;

        assign w_d = tfn_pkg::NUM_W'(s_len[g]) << SH;

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v <= 1'b0;
            end else begin
                r_v <= s_v[g];
            end
        end

        always_ff @(posedge i_clk) begin
            for (int k = 0; k < 3; k++) begin
                if (s_rem[g][k] >= w_d) begin
                    r_rem[k] <= s_rem[g][k] - w_d;
                    r_q[k]   <= s_q[g][k] | (tfn_pkg::Q_W'(1) << SH);
                end else begin
                    r_rem[k] <= s_rem[g][k];
                    r_q[k]   <= s_q[g][k];
                end
            end
            r_len  <= s_len[g];
            r_side <= s_side[g];
        end

        for (genvar k = 0; k < 3; k++) begin : g_lane
            assign s_rem[g+1][k] = r_rem[k];
            assign s_q[g+1][k]   = r_q[k];
        end
        assign s_len[g+1]  = r_len;
        assign s_side[g+1] = r_side;
        assign s_v[g+1]    = r_v;
    end

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            w_q[k] = (s_q[tfn_pkg::Q_W][k] > tfn_pkg::ONE_Q) ? tfn_pkg::ONE_Q
                                                              : s_q[tfn_pkg::Q_W][k];
            if (s_side[tfn_pkg::Q_W].degen) begin
                w_n[k] = '0;
            end else if (s_side[tfn_pkg::Q_W].neg[k]) begin
                w_n[k] = -signed'(tfn_pkg::OUT_W'(w_q[k]));
            end else begin
                w_n[k] = signed'(tfn_pkg::OUT_W'(w_q[k]));
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_strobe <= 1'b0;
        end else begin
            r_strobe <= s_v[tfn_pkg::Q_W];
        end
    end

    always_ff @(posedge i_clk) begin
        r_result.normal_x   <= w_n[0];
        r_result.normal_y   <= w_n[1];
        r_result.normal_z   <= w_n[2];
        r_result.degenerate <= s_side[tfn_pkg::Q_W].degen;
    end

    assign o_strobe = r_strobe;
    assign o_result = r_result;

endmodule
`default_nettype wire

### sv/tfn_checker.sv
// ----------------------------------------------------------------------------
// tfn_checker
// Port-level checks on latency and result consistency.
// ----------------------------------------------------------------------------
`default_nettype none
module tfn_checker (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             start,
    input  wire logic             busy,
    input  wire logic             o_strobe,
    input  wire tfn_pkg::t_result o_result
);

    localparam logic signed [tfn_pkg::OUT_W-1:0] ONE_N =
        tfn_pkg::OUT_W'(1) << tfn_pkg::NORMAL_FRAC_BITS;

    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |-> ##(tfn_pkg::LATENCY) o_strobe)
        else $error("transaction result missing");

    a_no_spurious: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(start && !busy) |-> ##(tfn_pkg::LATENCY) !o_strobe)
        else $error("result without transaction");

    a_degen_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && o_result.degenerate) |->
        (o_result.normal_x == '0 && o_result.normal_y == '0 && o_result.normal_z == '0))
        else $error("degenerate normal not zero");

    a_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && !o_result.degenerate) |->
        (o_result.normal_x <= ONE_N && o_result.normal_x >= -ONE_N &&
         o_result.normal_y <= ONE_N && o_result.normal_y >= -ONE_N &&
         o_result.normal_z <= ONE_N && o_result.normal_z >= -ONE_N &&
         (o_result.normal_x != '0 || o_result.normal_y != '0 ||
          o_result.normal_z != '0)))
        else $error("normal out of range");

endmodule

bind triangle_face_normal_unit tfn_checker u_tfn_checker (.*);
`default_nettype wire

### test/tb_triangle_face_normal_unit.sv
// ----------------------------------------------------------------------------
// tb_triangle_face_normal_unit
// Self-checking bench: random and corner triangles, normals predicted in SV.
// ----------------------------------------------------------------------------
`default_nettype none

class normal_scoreboard;
    tfn_pkg::t_result pending[$];
    int               mismatches;

    static function logic [63:0] isqrt(logic [63:0] num);
        logic [63:0] res;
        logic [63:0] bitv;
        res  = 0;
        bitv = 64'd1 << 62;
        while (bitv > num) bitv = bitv >> 2;
        while (bitv != 0) begin
            if (num >= res + bitv) begin
                num = num - (res + bitv);
                res = (res >> 1) + bitv;
            end else begin
                res = res >> 1;
            end
            bitv = bitv >> 2;
        end
        return res;
    endfunction

    static function tfn_pkg::t_result face_normal(tfn_pkg::t_tri t);
        tfn_pkg::t_result  r;
        logic signed [16:0] ax, ay, az, bx, by, bz;
        logic signed [40:0] c[3];
        logic [40:0]        mag[3];
        logic [40:0]        mx;
        logic [63:0]        m[3];
        logic [63:0]        sum, len, q;
        int                 blen;
        ax = 17'(t.p1_x) - 17'(t.p2_x);
        ay = 17'(t.p1_y) - 17'(t.p2_y);
        az = 17'(t.p1_z) - 17'(t.p2_z);
        bx = 17'(t.p1_x) - 17'(t.p3_x);
        by = 17'(t.p1_y) - 17'(t.p3_y);
        bz = 17'(t.p1_z) - 17'(t.p3_z);
        c[0] = 41'(ay) * 41'(bz) - 41'(by) * 41'(az);
        c[1] = 41'(bx) * 41'(az) - 41'(ax) * 41'(bz);
        c[2] = 41'(ax) * 41'(by) - 41'(bx) * 41'(ay);
        mx = 0;
        for (int i = 0; i < 3; i++) begin
            mag[i] = c[i] < 0 ? 41'(-c[i]) : 41'(c[i]);
            if (mag[i] > mx) mx = mag[i];
        end
        r = '0;
        if (mx == 0) begin
            r.degenerate = 1'b1;
            return r;
        end
        blen = 0;
        for (int i = 0; i < 41; i++) if (mx[i]) blen = i + 1;
        for (int i = 0; i < 3; i++)
            m[i] = blen > 31 ? 64'(mag[i] >> (blen - 31)) : 64'(mag[i]) << (31 - blen);
        sum = m[0] * m[0] + m[1] * m[1] + m[2] * m[2];
        len = isqrt(sum);
        if (len == 0) len = 1;
        for (int i = 0; i < 3; i++) begin
            q = ((m[i] << tfn_pkg::NORMAL_FRAC_BITS) + (len >> 1)) / len;
            if (q > (64'd1 << tfn_pkg::NORMAL_FRAC_BITS)) q = 64'd1 << tfn_pkg::NORMAL_FRAC_BITS;
            if (c[i] < 0) q = -q;
            case (i)
                0: r.normal_x = q[15:0];
                1: r.normal_y = q[15:0];
                default: r.normal_z = q[15:0];
            endcase
        end
        return r;
    endfunction

    function void note_triangle(tfn_pkg::t_tri t);
        pending.push_back(face_normal(t));
    endfunction

    function void check_normal(tfn_pkg::t_result got);
        tfn_pkg::t_result want;
        if (pending.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected result %h", got);
            return;
        end
        want = pending.pop_front();
        if (got.normal_x !== want.normal_x || got.normal_y !== want.normal_y ||
            got.normal_z !== want.normal_z || got.degenerate !== want.degenerate) begin
            mismatches++;
            if (mismatches <= 10)
                $display("mismatch: expected %0d %0d %0d deg %b, got %0d %0d %0d deg %b",
                         want.normal_x, want.normal_y, want.normal_z, want.degenerate,
                         got.normal_x, got.normal_y, got.normal_z, got.degenerate);
        end
    endfunction
endclass

module tb_triangle_face_normal_unit;

    logic             i_clk = 1'b0;
    logic             i_rst_n = 1'b0;
    logic             start = 1'b0;
    logic             busy;
    tfn_pkg::t_tri    i_tri = '0;
    logic             o_strobe;
    tfn_pkg::t_result o_result;

    normal_scoreboard sb = new();
    int idle_pct;

    triangle_face_normal_unit dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .start(start), .busy(busy),
        .i_tri(i_tri), .o_strobe(o_strobe), .o_result(o_result)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        if (i_rst_n && start && !busy) sb.note_triangle(i_tri);
        if (i_rst_n && o_strobe) sb.check_normal(o_result);
    end

    function automatic logic [15:0] rand_coord();
        case ($urandom_range(0, 5))
            0: return 16'h8000;
            1: return 16'h7fff;
            2: return 16'($urandom_range(0, 15)) - 16'd8;
            default: return 16'($urandom);
        endcase
    endfunction

    task automatic send_triangle(input tfn_pkg::t_tri t);
        while ($urandom_range(0, 99) < idle_pct) begin
            start <= 1'b0;
            @(posedge i_clk);
        end
        start <= 1'b1;
        i_tri <= t;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
    endtask

    task automatic send_random(input int count);
        tfn_pkg::t_tri t;
        for (int n = 0; n < count; n++) begin
            t.p1_x = rand_coord(); t.p1_y = rand_coord(); t.p1_z = rand_coord();
            t.p2_x = rand_coord(); t.p2_y = rand_coord(); t.p2_z = rand_coord();
            t.p3_x = rand_coord(); t.p3_y = rand_coord(); t.p3_z = rand_coord();
            case ($urandom_range(0, 9))
                0: begin
                    t.p2_x = t.p1_x;
                    t.p2_y = t.p1_y;
                    t.p2_z = t.p1_z;
                end
                1: begin
                    t.p3_x = t.p1_x;
                    t.p3_y = t.p1_y;
                    t.p3_z = t.p1_z;
                end
                default: ;
            endcase
            send_triangle(t);
        end
    endtask

    initial begin
        idle_pct = 0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        idle_pct = 36;
        send_random(483);
        idle_pct = 60;
        send_random(483);
        idle_pct = 0;
        send_random(484);
        start <= 1'b0;
        repeat (tfn_pkg::LATENCY + 8) @(posedge i_clk);
        if (sb.mismatches == 0 && sb.pending.size() == 0)
            $display("triangle_face_normal_unit regression: pass");
        else
            $display("triangle_face_normal_unit regression: fail");
        $finish;
    end

    initial begin
        #3000000;
        $display("triangle_face_normal_unit regression: fail");
        $finish;
    end
endmodule

`default_nettype wire

### files.f
sv/tfn_pkg.sv
sv/tfn_front.sv
sv/tfn_sqrt.sv
sv/tfn_div.sv
sv/triangle_face_normal_unit.sv
sv/tfn_checker.sv
test/tb_triangle_face_normal_unit.sv
